// ----- rtl/csu_pkg.sv -----
// Package for the cosine similarity unit: shared widths, result constants
// and the bundle of running sums passed from the accumulator to the top level.
// No dependencies.
package csu_pkg;

    // Widths of the running sums.
    localparam int DOT_W = 42;
    localparam int SQ_W  = 41;

    // Magnitude of the dot sum, and the working width of the ratio datapath.
    localparam int MAG_W  = 42;
    localparam int WIDE_W = 120;

    // The squared dot sum is scaled by 2^32 (Q15 result, squared, times four).
    localparam int SCALE_SHIFT = 32;

    // The quotient search resolves this many bits, most significant first.
    localparam int ROOT_BITS  = 16;
    localparam int ROOT_IDX_W = $clog2(ROOT_BITS);
    localparam int MUL_CNT_W  = $clog2(MAG_W);

    // Result format.
    localparam int SIM_W = 16;
    localparam logic [ROOT_BITS-1:0] Q_FULL      = 16'h8000;
    localparam logic [SIM_W-1:0]     SIM_POS_MAX = 16'h7FFF;

    // Running sums and the length flag, as the accumulator holds them.
    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [SQ_W-1:0]         lsq;
        logic [SQ_W-1:0]         rsq;
        logic                    overflow;
    } csu_sums_t;

endpackage

// ----- rtl/csu_mac.sv -----
// Element accumulator: one signed multiplier shared over the three products
// of an element pair, followed by saturating accumulation of the sums.
// Depends on csu_pkg.
module csu_mac
    import csu_pkg::*;
#(
    parameter int ELEMENT_BITS = 16,
    parameter int MAX_LENGTH   = 1024
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           clear,
    input  logic signed [ELEMENT_BITS-1:0] left_value,
    input  logic signed [ELEMENT_BITS-1:0] right_value,
    output logic                           done,
    output csu_sums_t                      sums
);

    localparam int PROD_W = 2 * ELEMENT_BITS;
    localparam int ACC_W  = ((PROD_W > DOT_W) ? PROD_W : DOT_W) + 1;
    localparam int CNT_W  = $clog2(MAX_LENGTH + 1);

    localparam logic [ACC_W-1:0] ACC_ONE = ACC_W'(1);
    localparam logic [ACC_W-1:0] DOT_HI  = (ACC_ONE << (DOT_W - 1)) - ACC_ONE;
    localparam logic [ACC_W-1:0] DOT_LO  = ~DOT_HI;
    localparam logic [ACC_W-1:0] SQ_HI   = (ACC_ONE << SQ_W) - ACC_ONE;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_LENGTH);

    typedef enum logic [1:0] {P_IDLE, P_DOT, P_LSQ, P_RSQ} phase_t;

    phase_t                    phase_reg;
    phase_t                    sel_reg;
    logic                      skip_reg;
    logic                      done_reg;
    logic signed [DOT_W-1:0]   dot_reg;
    logic [SQ_W-1:0]           lsq_reg;
    logic [SQ_W-1:0]           rsq_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      ovf_reg;

    logic signed [ELEMENT_BITS-1:0] a_reg;
    logic signed [ELEMENT_BITS-1:0] b_reg;
    logic signed [PROD_W-1:0]       prod_reg;

    logic signed [ELEMENT_BITS-1:0] mul_x;
    logic signed [ELEMENT_BITS-1:0] mul_y;
    logic signed [PROD_W-1:0]       prod_next;
    logic [ACC_W-1:0]               prod_ext;
    logic [ACC_W-1:0]               dot_add;
    logic [ACC_W-1:0]               sq_add;
    logic [SQ_W-1:0]                sq_in;
    logic [DOT_W-1:0]               dot_clamped;
    logic [SQ_W-1:0]                sq_clamped;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        unique case (phase_reg)
            P_DOT:
            begin
                mul_x = a_reg;
                mul_y = b_reg;
            end
            P_LSQ:
            begin
                mul_x = a_reg;
                mul_y = a_reg;
            end
            P_RSQ:
            begin
                mul_x = b_reg;
                mul_y = b_reg;
            end
            P_IDLE:
            begin
                mul_x = a_reg;
                mul_y = b_reg;
            end
        endcase
        prod_next = mul_x * mul_y;
    end

    // Saturating accumulation of the registered product.
    always_comb
    begin
        prod_ext = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        dot_add  = {{(ACC_W - DOT_W){dot_reg[DOT_W-1]}}, dot_reg} + prod_ext;
        sq_in    = (sel_reg == P_LSQ) ? lsq_reg : rsq_reg;
        sq_add   = {{(ACC_W - SQ_W){1'b0}}, sq_in} + prod_ext;

        if ($signed(dot_add) > $signed(DOT_HI))
            dot_clamped = DOT_HI[DOT_W-1:0];
        else if ($signed(dot_add) < $signed(DOT_LO))
            dot_clamped = DOT_LO[DOT_W-1:0];
        else
            dot_clamped = dot_add[DOT_W-1:0];

        if ($signed(sq_add) > $signed(SQ_HI))
            sq_clamped = SQ_HI[SQ_W-1:0];
        else
            sq_clamped = sq_add[SQ_W-1:0];
    end

    // Operand and product registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= left_value;
            b_reg <= right_value;
        end
        prod_reg <= prod_next;
    end

    // Sequencer and running sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            sel_reg   <= P_IDLE;
            skip_reg  <= 1'b0;
            done_reg  <= 1'b0;
            dot_reg   <= '0;
            lsq_reg   <= '0;
            rsq_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            sel_reg  <= phase_reg;

            if (start)
            begin
                phase_reg <= P_DOT;
                skip_reg  <= (count_reg == CNT_FULL);
            end
            else
            begin
                unique case (phase_reg)
                    P_DOT:  phase_reg <= P_LSQ;
                    P_LSQ:  phase_reg <= P_RSQ;
                    P_RSQ:  phase_reg <= P_IDLE;
                    P_IDLE: phase_reg <= P_IDLE;
                endcase
            end

            // A pair past the length limit only marks the overflow.
            unique case (sel_reg)
                P_DOT:
                begin
                    if (!skip_reg)
                        dot_reg <= dot_clamped;
                end
                P_LSQ:
                begin
                    if (!skip_reg)
                        lsq_reg <= sq_clamped;
                end
                P_RSQ:
                begin
                    if (!skip_reg)
                    begin
                        rsq_reg   <= sq_clamped;
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_reg <= 1'b1;
                    end
                    done_reg <= 1'b1;
                end
                P_IDLE:
                begin
                end
            endcase

            if (clear)
            begin
                dot_reg   <= '0;
                lsq_reg   <= '0;
                rsq_reg   <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    assign done          = done_reg;
    assign sums.dot      = dot_reg;
    assign sums.lsq      = lsq_reg;
    assign sums.rsq      = rsq_reg;
    assign sums.overflow = ovf_reg;

endmodule

// ----- rtl/csu_ratio.sv -----
// Ratio unit: one shared wide adder under a sequencer forms L*R and
// |dot|^2 by shift and add, then finds the rounded quotient bit by bit.
// Depends on csu_pkg.
module csu_ratio
    import csu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MAG_W-1:0]     mag,
    input  logic [SQ_W-1:0]      lsq,
    input  logic [SQ_W-1:0]      rsq,
    output logic                 done,
    output logic [ROOT_BITS-1:0] q
);

    typedef enum logic [2:0] {
        R_IDLE, R_NORM, R_SQ, R_INIT_E, R_INIT_U, R_SUM, R_TEST, R_STEP
    } rstate_t;

    rstate_t                  state_reg;
    logic signed [WIDE_W-1:0] acc_reg;
    logic signed [WIDE_W-1:0] e_reg;
    logic signed [WIDE_W-1:0] u_reg;
    logic signed [WIDE_W-1:0] n_reg;
    logic signed [WIDE_W-1:0] qs_reg;
    logic [MAG_W-1:0]         mcand_reg;
    logic [MAG_W-1:0]         mplier_reg;
    logic [MUL_CNT_W-1:0]     cnt_reg;
    logic [ROOT_IDX_W-1:0]    k_reg;
    logic                     hit_reg;
    logic [ROOT_BITS-1:0]     q_reg;
    logic                     done_reg;

    logic signed [WIDE_W-1:0] op_a;
    logic signed [WIDE_W-1:0] op_b;
    logic signed [WIDE_W-1:0] sum;
    logic                     sub;

    // Shared adder and its operand selection. With the candidate bit b,
    // x = 2q-1, N = L*R and M = |dot|^2 * 2^32, the sequencer keeps
    // E = M - x^2 N, U = b x N and Q = b^2 N; a bit is taken when
    // E - 4(U + Q) is not negative.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        sub  = 1'b0;
        unique case (state_reg)
            R_NORM, R_SQ:
            begin
                op_a = acc_reg << 1;
                op_b = mplier_reg[MAG_W-1] ? WIDE_W'(mcand_reg) : '0;
            end
            R_INIT_E:
            begin
                op_a = e_reg;
                op_b = n_reg;
                sub  = 1'b1;
            end
            R_INIT_U:
            begin
                op_b = n_reg << (ROOT_BITS - 1);
                sub  = 1'b1;
            end
            R_SUM:
            begin
                op_a = u_reg;
                op_b = qs_reg;
            end
            R_TEST:
            begin
                op_a = e_reg;
                op_b = acc_reg << 2;
                sub  = 1'b1;
            end
            R_STEP:
            begin
                op_a = acc_reg;
                op_b = qs_reg;
            end
            R_IDLE:
            begin
            end
        endcase
        sum = op_a + (op_b ^ {WIDE_W{sub}}) + WIDE_W'(sub);
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= R_IDLE;
            acc_reg    <= '0;
            e_reg      <= '0;
            u_reg      <= '0;
            n_reg      <= '0;
            qs_reg     <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            cnt_reg    <= '0;
            k_reg      <= '0;
            hit_reg    <= 1'b0;
            q_reg      <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        acc_reg    <= '0;
                        e_reg      <= WIDE_W'(mag);
                        mcand_reg  <= MAG_W'(lsq);
                        mplier_reg <= MAG_W'(rsq);
                        cnt_reg    <= MUL_CNT_W'(MAG_W - 1);
                        q_reg      <= '0;
                        state_reg  <= R_NORM;
                    end
                end
                // Product of the two norms, one multiplier bit per cycle.
                R_NORM:
                begin
                    acc_reg    <= sum;
                    mplier_reg <= mplier_reg << 1;
                    cnt_reg    <= cnt_reg - MUL_CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        n_reg      <= sum;
                        acc_reg    <= '0;
                        mcand_reg  <= e_reg[MAG_W-1:0];
                        mplier_reg <= e_reg[MAG_W-1:0];
                        cnt_reg    <= MUL_CNT_W'(MAG_W - 1);
                        state_reg  <= R_SQ;
                    end
                end
                // Square of the dot magnitude, then scaled.
                R_SQ:
                begin
                    acc_reg    <= sum;
                    mplier_reg <= mplier_reg << 1;
                    cnt_reg    <= cnt_reg - MUL_CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        e_reg     <= sum << SCALE_SHIFT;
                        state_reg <= R_INIT_E;
                    end
                end
                R_INIT_E:
                begin
                    e_reg     <= sum;
                    state_reg <= R_INIT_U;
                end
                R_INIT_U:
                begin
                    u_reg     <= sum;
                    qs_reg    <= n_reg << (2 * (ROOT_BITS - 1));
                    k_reg     <= ROOT_IDX_W'(ROOT_BITS - 1);
                    state_reg <= R_SUM;
                end
                R_SUM:
                begin
                    acc_reg   <= sum;
                    state_reg <= R_TEST;
                end
                R_TEST:
                begin
                    hit_reg <= !sum[WIDE_W-1];
                    if (!sum[WIDE_W-1])
                    begin
                        e_reg        <= sum;
                        q_reg[k_reg] <= 1'b1;
                    end
                    state_reg <= R_STEP;
                end
                // Move U and Q on to the next lower bit.
                R_STEP:
                begin
                    u_reg  <= hit_reg ? (sum >>> 1) : (u_reg >>> 1);
                    qs_reg <= qs_reg >> 2;
                    if (k_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= R_IDLE;
                    end
                    else
                    begin
                        k_reg     <= k_reg - ROOT_IDX_W'(1);
                        state_reg <= R_SUM;
                    end
                end
            endcase
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

// ----- rtl/cosine_similarity_unit.sv -----
// Cosine similarity unit: dot / sqrt(|left|^2 * |right|^2) in signed Q1.15.
// Each element pair is taken only in the idle state: in_stall holds off the next pair
// until the accumulator's multiplier, shared over three products, has finished it.
// After the last pair the result waits on the ratio unit (skipped on zero norm),
// set by its single adder: 42 + 42 multiply steps and 16 x 3 search steps.
// Reset (rst_n, asynchronous, active low) clears all sums, flags and the output.
module cosine_similarity_unit
    import csu_pkg::*;
#(
    parameter int MAX_LENGTH   = 1024,
    parameter int ELEMENT_BITS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [ELEMENT_BITS-1:0] left_value,
    input  logic signed [ELEMENT_BITS-1:0] right_value,
    input  logic                           last,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SIM_W-1:0]        similarity,
    output logic                           zero_norm,
    output logic                           length_overflow
);

    typedef enum logic [1:0] {S_IDLE, S_MAC, S_RATIO, S_FINISH} state_t;

    state_t           state_reg;
    logic             last_reg;
    logic             neg_reg;
    logic             zero_reg;
    logic             ovf_reg;
    logic [SIM_W-1:0] res_reg;
    logic             out_valid_reg;
    logic [SIM_W-1:0] similarity_reg;
    logic             zero_norm_reg;
    logic             length_overflow_reg;

    logic                 accept_in;
    logic                 mac_done;
    logic                 mac_clear;
    csu_sums_t            sums;
    logic                 norm_zero;
    logic                 dot_neg;
    logic [MAG_W-1:0]     dot_bits;
    logic [MAG_W-1:0]     mag;
    logic                 ratio_start;
    logic                 ratio_done;
    logic [ROOT_BITS-1:0] ratio_q;
    logic [ROOT_BITS-1:0] q_clip;
    logic [SIM_W-1:0]     sim_value;
    logic                 out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept_in = in_valid && (state_reg == S_IDLE);

    csu_mac #(
        .ELEMENT_BITS (ELEMENT_BITS),
        .MAX_LENGTH   (MAX_LENGTH)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept_in),
        .clear       (mac_clear),
        .left_value  (left_value),
        .right_value (right_value),
        .done        (mac_done),
        .sums        (sums)
    );

    // Hand-off of the finished sums to the ratio unit.
    assign mac_clear   = (state_reg == S_MAC) && mac_done && last_reg;
    assign norm_zero   = (sums.lsq == '0) || (sums.rsq == '0);
    assign dot_neg     = sums.dot[DOT_W-1];
    assign dot_bits    = sums.dot;
    assign mag         = dot_neg ? (~dot_bits + MAG_W'(1)) : dot_bits;
    assign ratio_start = mac_clear && !norm_zero;

    csu_ratio u_ratio (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ratio_start),
        .mag   (mag),
        .lsq   (sums.lsq),
        .rsq   (sums.rsq),
        .done  (ratio_done),
        .q     (ratio_q)
    );

    // Sign and saturation of the quotient.
    always_comb
    begin
        q_clip = (ratio_q > Q_FULL) ? Q_FULL : ratio_q;
        if (neg_reg)
            sim_value = SIM_W'(0) - q_clip;
        else if (q_clip > SIM_POS_MAX)
            sim_value = SIM_POS_MAX;
        else
            sim_value = q_clip;
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Control sequence and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            last_reg            <= 1'b0;
            neg_reg             <= 1'b0;
            zero_reg            <= 1'b0;
            ovf_reg             <= 1'b0;
            res_reg             <= '0;
            out_valid_reg       <= 1'b0;
            similarity_reg      <= '0;
            zero_norm_reg       <= 1'b0;
            length_overflow_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept_in)
                    begin
                        last_reg  <= last;
                        state_reg <= S_MAC;
                    end
                end
                S_MAC:
                begin
                    if (mac_done)
                    begin
                        if (!last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            zero_reg  <= norm_zero;
                            ovf_reg   <= sums.overflow;
                            neg_reg   <= dot_neg;
                            res_reg   <= '0;
                            state_reg <= norm_zero ? S_FINISH : S_RATIO;
                        end
                    end
                end
                S_RATIO:
                begin
                    if (ratio_done)
                    begin
                        res_reg   <= sim_value;
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg       <= 1'b1;
                        similarity_reg      <= res_reg;
                        zero_norm_reg       <= zero_reg;
                        length_overflow_reg <= ovf_reg;
                        state_reg           <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign similarity      = similarity_reg;
    assign zero_norm       = zero_norm_reg;
    assign length_overflow = length_overflow_reg;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for cosine_similarity_unit: streams vector pairs, predicts the
// Q1.15 similarity, zero-norm and length-overflow flags, and checks every result item.
// Depends on rtl/csu_pkg.sv and rtl/cosine_similarity_unit.sv.
module tb;
    import csu_pkg::*;

    localparam int ELEM_W       = 16;
    localparam int MAX_PAIRS    = 1024;
    localparam int RANDOM_PAIRS = 600;
    localparam int HOLD_AFTER   = 6;
    localparam int HOLD_LEN     = 500;
    localparam int DRAIN_CYCLES = 300;
    localparam int RUN_LIMIT    = 400000;
    localparam int REPORT_MAX   = 10;

    localparam longint DOT_HI = (longint'(1) <<< (DOT_W - 1)) - 1;
    localparam longint DOT_LO = -DOT_HI - 1;
    localparam longint SQ_HI  = (longint'(1) <<< SQ_W) - 1;

    // How the right element of a vector pair relates to the left one.
    typedef enum int {
        REL_INDEPENDENT,
        REL_SAME,
        REL_NEGATED,
        REL_NEAR,
        REL_LEFT_ZERO,
        REL_RIGHT_ZERO
    } pair_relation_t;

    typedef struct {
        logic signed [ELEM_W-1:0] left_elem;
        logic signed [ELEM_W-1:0] right_elem;
        logic                     is_last;
    } pair_t;

    typedef struct {
        logic signed [SIM_W-1:0] sim;
        logic                    zero;
        logic                    over;
    } sim_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [ELEM_W-1:0] left_value = '0;
    logic signed [ELEM_W-1:0] right_value = '0;
    logic last = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [SIM_W-1:0] similarity;
    logic zero_norm;
    logic length_overflow;

    // Running sums of the vector pair in flight.
    logic signed [DOT_W-1:0] acc_dot = '0;
    logic [SQ_W-1:0] acc_lsq = '0;
    logic [SQ_W-1:0] acc_rsq = '0;
    int acc_count = 0;
    logic acc_too_long = 1'b0;

    pair_t pair_q[$];
    sim_result_t due_results[$];
    pair_t next_pair;
    sim_result_t want;

    int src_wait;
    logic src_steady;
    int sink_wait;
    int sink_next;
    logic sink_steady;
    int results_seen;
    int hold_cycles;
    logic hold_done;
    int mismatches = 0;
    int cycle_count = 0;

    cosine_similarity_unit #(
        .MAX_LENGTH   (MAX_PAIRS),
        .ELEMENT_BITS (ELEM_W)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .left_value      (left_value),
        .right_value     (right_value),
        .last            (last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .similarity      (similarity),
        .zero_norm       (zero_norm),
        .length_overflow (length_overflow)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Largest q in [0, 2^15] with q <= mag * 2^15 / sqrt(lsq * rsq) + 1/2, found by
    // comparing (2q - 1)^2 * lsq * rsq against mag^2 * 2^32 in exact integers.
    function automatic int root_ratio_q15(logic [63:0] mag, logic [63:0] lsq, logic [63:0] rsq);
        logic [127:0] norms;
        logic [127:0] scaled_dot;
        logic [127:0] odd;
        int lo;
        int hi;
        int mid;
        norms = 128'(lsq) * 128'(rsq);
        scaled_dot = (128'(mag) * 128'(mag)) << SCALE_SHIFT;
        lo = 0;
        hi = int'(Q_FULL);
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            odd = 128'(2 * mid - 1);
            if (odd * odd * norms <= scaled_dot)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // Accumulates one accepted pair; on the final pair, queues the result item and clears.
    function automatic void add_pair(logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b,
                                     logic fin);
        longint d;
        longint l;
        longint r;
        longint mag;
        int q;
        sim_result_t res;
        if (acc_count >= MAX_PAIRS)
        begin
            acc_too_long = 1'b1;
        end
        else
        begin
            d = longint'(acc_dot) + longint'(a) * longint'(b);
            if (d > DOT_HI)
                d = DOT_HI;
            if (d < DOT_LO)
                d = DOT_LO;
            l = longint'(acc_lsq) + longint'(a) * longint'(a);
            if (l > SQ_HI)
                l = SQ_HI;
            r = longint'(acc_rsq) + longint'(b) * longint'(b);
            if (r > SQ_HI)
                r = SQ_HI;
            acc_dot = DOT_W'(d);
            acc_lsq = SQ_W'(l);
            acc_rsq = SQ_W'(r);
            acc_count++;
        end
        if (!fin)
            return;

        res.sim = '0;
        res.zero = 1'b0;
        res.over = acc_too_long;
        if (acc_lsq == '0 || acc_rsq == '0)
        begin
            res.zero = 1'b1;
        end
        else
        begin
            mag = (acc_dot < 0) ? -longint'(acc_dot) : longint'(acc_dot);
            q = root_ratio_q15(64'(mag), 64'(acc_lsq), 64'(acc_rsq));
            if (acc_dot < 0)
                res.sim = SIM_W'(-q);
            else if (q > int'(SIM_POS_MAX))
                res.sim = SIM_POS_MAX;
            else
                res.sim = SIM_W'(q);
        end
        due_results.push_back(res);

        acc_dot = '0;
        acc_lsq = '0;
        acc_rsq = '0;
        acc_count = 0;
        acc_too_long = 1'b0;
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%s", msg);
    endfunction

    function automatic logic signed [ELEM_W-1:0] draw_element();
        logic signed [ELEM_W-1:0] e;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: e = 16'sh8000;
                    1: e = 16'sh7FFF;
                    2: e = 16'sh0000;
                    3: e = -16'sd1;
                    default: e = 16'sd1;
                endcase
            end
            1, 2: e = ELEM_W'($urandom_range(0, 511)) - 16'sd256;
            default: e = ELEM_W'($urandom);
        endcase
        return e;
    endfunction

    task automatic push_pair(logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b, logic fin);
        pair_t p;
        p.left_elem = a;
        p.right_elem = b;
        p.is_last = fin;
        pair_q.push_back(p);
    endtask

    task automatic push_vector(int n, pair_relation_t rel);
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        for (int i = 0; i < n; i++)
        begin
            a = draw_element();
            b = draw_element();
            case (rel)
                REL_SAME:       b = a;
                REL_NEGATED:    b = -a;
                REL_NEAR:       b = a + ELEM_W'($urandom_range(0, 64)) - 16'sd32;
                REL_LEFT_ZERO:  a = '0;
                REL_RIGHT_ZERO: b = '0;
                default:        ;
            endcase
            push_pair(a, b, i == n - 1);
        end
    endtask

    // Source side: offers queued items, waiting a drawn number of cycles between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            left_value <= '0;
            right_value <= '0;
            last <= 1'b0;
            src_wait <= 0;
            src_steady <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                add_pair(left_value, right_value, last);
            if (!in_valid || !in_stall)
            begin
                if (src_wait != 0)
                begin
                    in_valid <= 1'b0;
                    src_wait <= src_wait - 1;
                end
                else if (pair_q.size() != 0)
                begin
                    next_pair = pair_q.pop_front();
                    left_value <= next_pair.left_elem;
                    right_value <= next_pair.right_elem;
                    last <= next_pair.is_last;
                    in_valid <= 1'b1;
                    src_wait <= src_steady ? 0 : $urandom_range(0, 4);
                    if ($urandom_range(0, 29) == 0)
                        src_steady <= !src_steady;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Sink side: checks each accepted result item and stalls a drawn number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            sink_wait <= 0;
            sink_steady <= 1'b0;
            results_seen <= 0;
        end
        else
        begin
            sink_next = sink_wait;
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    note_mismatch($sformatf("Unexpected result: sim=%0d zero=%0b over=%0b",
                                            similarity, zero_norm, length_overflow));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (similarity !== want.sim || zero_norm !== want.zero ||
                        length_overflow !== want.over)
                        note_mismatch($sformatf(
                            {"Result %0d: expected sim=%0d zero=%0b over=%0b, ",
                             "got sim=%0d zero=%0b over=%0b"},
                            results_seen, want.sim, want.zero, want.over,
                            similarity, zero_norm, length_overflow));
                end
                results_seen <= results_seen + 1;
                sink_next = sink_steady ? 0 : $urandom_range(0, 4);
                if ($urandom_range(0, 9) == 0)
                    sink_steady <= !sink_steady;
            end
            else if (sink_next != 0)
            begin
                sink_next = sink_next - 1;
            end
            sink_wait <= sink_next;
            out_stall <= (hold_cycles != 0) || (sink_next != 0);
        end
    end

    // One long output hold-off so the block fills up and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycles <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_seen == HOLD_AFTER)
        begin
            hold_cycles <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_cycles != 0)
        begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int vec;
        int len;
        int pick;
        int random_pairs;
        pair_relation_t rel;

        // Directed: extremes, full correlation and anticorrelation, zero norms.
        push_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
        push_pair(16'sh8000, 16'sh8000, 1'b1);
        push_pair(16'sh8000, 16'sh7FFF, 1'b1);
        push_pair(16'sh7FFF, 16'sh8000, 1'b1);
        push_pair(16'sd1, -16'sd1, 1'b1);
        push_pair(16'sd0, 16'sd1234, 1'b1);
        push_pair(-16'sd5, 16'sd0, 1'b1);
        push_pair(16'sd0, 16'sd0, 1'b1);
        push_pair(16'sd100, 16'sd0, 1'b0);
        push_pair(16'sd0, 16'sd100, 1'b1);
        push_pair(16'sh7FFF, 16'sh8000, 1'b0);
        push_pair(16'sd1, 16'sd1, 1'b0);
        push_pair(-16'sd1, 16'sd2, 1'b1);
        push_pair(16'sd0, 16'sd0, 1'b0);
        push_pair(16'sd0, 16'sd0, 1'b0);
        push_pair(16'sh5555, -16'sh2AAA, 1'b1);
        push_pair(16'sh4000, 16'sh4000, 1'b0);
        push_pair(-16'sh4000, -16'sh4000, 1'b1);

        // Random vector pairs, mostly short with an occasional longer one.
        random_pairs = 0;
        for (vec = 0; random_pairs < RANDOM_PAIRS; vec++)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            pick = $urandom_range(0, 9);
            case (pick)
                0:       rel = REL_LEFT_ZERO;
                1:       rel = REL_RIGHT_ZERO;
                2, 3:    rel = REL_SAME;
                4, 5:    rel = REL_NEGATED;
                6, 7:    rel = REL_NEAR;
                default: rel = REL_INDEPENDENT;
            endcase
            push_vector(len, rel);
            random_pairs += len;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (pair_q.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
